/* rtl/gawp_pkg.sv */
// Shared types and constants for the G-code axis word parser.
// No dependencies; every other file in rtl imports this package.
package gawp_pkg;

    // default magnitude width of one axis value
    localparam int VALUE_BITS_DEF = 20;

    // reset value of the reciprocal unit register, Q8.24 one
    localparam logic [31:0] INV_UNIT_RESET = 32'd16777216;

    // recognized characters
    localparam logic [7:0] CHAR_G     = "G";
    localparam logic [7:0] CHAR_X     = "X";
    localparam logic [7:0] CHAR_Y     = "Y";
    localparam logic [7:0] CHAR_Z     = "Z";
    localparam logic [7:0] CHAR_0     = "0";
    localparam logic [7:0] CHAR_1     = "1";
    localparam logic [7:0] CHAR_2     = "2";
    localparam logic [7:0] CHAR_9     = "9";
    localparam logic [7:0] CHAR_PLUS  = "+";
    localparam logic [7:0] CHAR_MINUS = "-";
    localparam logic [7:0] CHAR_SPACE = " ";
    localparam logic [7:0] CHAR_TAB   = 8'd9;
    localparam logic [7:0] CHAR_CR    = 8'd13;

    // axis being read: none, then X, Y, Z
    localparam logic [1:0] AXIS_NONE = 2'd0;

    // number of axes
    localparam int AXES = 3;

    // progress of one axis number read
    typedef enum logic [1:0] {
        RP_IDLE,
        RP_LEAD,
        RP_NUM
    } read_phase_t;

    // kind of move reported with each line
    typedef enum logic [1:0] {
        MOVE_G0,
        MOVE_G1,
        MOVE_UNKNOWN,
        MOVE_NOT_G
    } move_kind_t;

    // input beat: one character
    typedef struct packed {
        logic [7:0] char_in;
        logic       line_end;
    } item_t;

    // output beat: one parsed line
    typedef struct packed {
        logic signed [31:0] x_pos;
        logic signed [31:0] y_pos;
        logic signed [31:0] z_pos;
        logic [1:0]         move_kind;
    } result_t;

    // per line control handed from the parser to the scaling stages
    typedef struct packed {
        logic [AXES-1:0] neg;
        move_kind_t      kind;
    } line_info_t;

endpackage

/* rtl/gawp_parse.sv */
// Character parser: per-line state register, atoi style axis reads, and
// the captured line record. Depends on gawp_pkg.
module gawp_parse
    import gawp_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             item_valid,
    input  item_t                            item,
    output logic                             item_stall,
    input  logic                             line_take,
    output logic                             line_valid,
    output logic [AXES-1:0][VALUE_BITS-1:0]  line_mag,
    output line_info_t                       line_info
);

    localparam int WW = VALUE_BITS + 4;
    localparam logic [VALUE_BITS-1:0] CAP = {VALUE_BITS{1'b1}};

    // line state
    logic [1:0]                     char_pos_reg,   char_pos_next;
    logic                           lead_g_reg,     lead_g_next;
    logic [7:0]                     code_char_reg,  code_char_next;
    logic [1:0]                     active_reg,     active_next;
    read_phase_t                    phase_reg,      phase_next;
    logic                           neg_sign_reg,   neg_sign_next;
    logic [AXES-1:0]                seen_reg,       seen_next;
    logic [AXES-1:0][VALUE_BITS-1:0] mag_reg,       mag_next;
    logic [AXES-1:0]                axneg_reg,      axneg_next;

    // captured line record
    logic                            line_valid_reg;
    logic [AXES-1:0][VALUE_BITS-1:0] line_mag_reg, line_mag_next;
    line_info_t                      line_info_reg, line_info_next;

    logic            accept;
    logic [7:0]      c;
    logic            is_digit;
    logic            is_space;
    logic            add_digit;
    logic [7:0]      cdiff;
    logic [3:0]      dval;
    logic [AXES-1:0] letter_hit;
    logic            parsed;
    move_kind_t      kind;
    logic [WW-1:0]   wide [AXES];

    // the record slot must be free, or freeing, to take a character
    assign item_stall = line_valid_reg && !line_take;
    assign accept     = item_valid && !item_stall;

    assign c        = item.char_in;
    assign is_digit = (c >= CHAR_0) && (c <= CHAR_9);
    assign is_space = (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
    assign cdiff    = c - CHAR_0;
    assign dval     = cdiff[3:0];

    assign letter_hit[0] = (c == CHAR_X);
    assign letter_hit[1] = (c == CHAR_Y);
    assign letter_hit[2] = (c == CHAR_Z);

    // next line state for the current character
    always_comb
    begin
        char_pos_next  = char_pos_reg;
        lead_g_next    = lead_g_reg;
        code_char_next = code_char_reg;
        active_next    = active_reg;
        phase_next     = phase_reg;
        neg_sign_next  = neg_sign_reg;
        seen_next      = seen_reg;
        mag_next       = mag_reg;
        axneg_next     = axneg_reg;
        add_digit      = 1'b0;

        // first two characters: G and the code character
        if (char_pos_reg == 2'd0)
        begin
            lead_g_next = (c == CHAR_G);
        end
        else if (char_pos_reg == 2'd1)
        begin
            code_char_next = c;
        end
        if (char_pos_reg < 2'd2)
        begin
            char_pos_next = char_pos_reg + 2'd1;
        end

        // number read in progress
        unique case (phase_reg)
            RP_IDLE:
            begin
            end
            RP_LEAD:
            begin
                if (is_space)
                begin
                end
                else if ((c == CHAR_PLUS) || (c == CHAR_MINUS))
                begin
                    neg_sign_next = (c == CHAR_MINUS);
                    phase_next    = RP_NUM;
                end
                else if (is_digit)
                begin
                    phase_next = RP_NUM;
                    add_digit  = 1'b1;
                end
                else
                begin
                    active_next   = AXIS_NONE;
                    phase_next    = RP_IDLE;
                    neg_sign_next = 1'b0;
                end
            end
            RP_NUM:
            begin
                if (is_digit)
                begin
                    add_digit = 1'b1;
                end
                else
                begin
                    active_next   = AXIS_NONE;
                    phase_next    = RP_IDLE;
                    neg_sign_next = 1'b0;
                end
            end
            default:
            begin
                active_next   = AXIS_NONE;
                phase_next    = RP_IDLE;
                neg_sign_next = 1'b0;
            end
        endcase

        // accumulate a digit into the active axis, saturating
        for (int a = 0; a < AXES; a++)
        begin
            wide[a] = WW'(mag_reg[a]) * WW'(10) + WW'(dval);
            if (add_digit && (active_reg == 2'(a + 1)))
            begin
                mag_next[a]   = (wide[a] > WW'(CAP)) ? CAP : wide[a][VALUE_BITS-1:0];
                axneg_next[a] = neg_sign_reg;
            end
        end

        // first letter of an axis starts its read
        for (int a = 0; a < AXES; a++)
        begin
            if ((phase_next == RP_IDLE) && letter_hit[a] && !seen_reg[a])
            begin
                seen_next[a]  = 1'b1;
                mag_next[a]   = '0;
                axneg_next[a] = 1'b0;
                active_next   = 2'(a + 1);
                phase_next    = RP_LEAD;
                neg_sign_next = 1'b0;
            end
        end
    end

    // move kind and whether axes count
    always_comb
    begin
        if (!lead_g_next)
        begin
            kind = MOVE_NOT_G;
        end
        else if (code_char_next == CHAR_0)
        begin
            kind = MOVE_G0;
        end
        else if (code_char_next == CHAR_1)
        begin
            kind = MOVE_G1;
        end
        else
        begin
            kind = MOVE_UNKNOWN;
        end
        parsed = lead_g_next && !((code_char_next >= CHAR_2) && (code_char_next <= CHAR_9));

        for (int a = 0; a < AXES; a++)
        begin
            line_mag_next[a] = parsed ? mag_next[a] : '0;
        end
        line_info_next.neg  = parsed ? axneg_next : '0;
        line_info_next.kind = kind;
    end

    // line state register, cleared after every line end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_pos_reg  <= 2'd0;
            lead_g_reg    <= 1'b0;
            code_char_reg <= '0;
            active_reg    <= AXIS_NONE;
            phase_reg     <= RP_IDLE;
            neg_sign_reg  <= 1'b0;
            seen_reg      <= '0;
            mag_reg       <= '0;
            axneg_reg     <= '0;
        end
        else if (accept)
        begin
            if (item.line_end)
            begin
                char_pos_reg  <= 2'd0;
                lead_g_reg    <= 1'b0;
                code_char_reg <= '0;
                active_reg    <= AXIS_NONE;
                phase_reg     <= RP_IDLE;
                neg_sign_reg  <= 1'b0;
                seen_reg      <= '0;
                mag_reg       <= '0;
                axneg_reg     <= '0;
            end
            else
            begin
                char_pos_reg  <= char_pos_next;
                lead_g_reg    <= lead_g_next;
                code_char_reg <= code_char_next;
                active_reg    <= active_next;
                phase_reg     <= phase_next;
                neg_sign_reg  <= neg_sign_next;
                seen_reg      <= seen_next;
                mag_reg       <= mag_next;
                axneg_reg     <= axneg_next;
            end
        end
    end

    // record valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_valid_reg <= 1'b0;
        end
        else if (accept && item.line_end)
        begin
            line_valid_reg <= 1'b1;
        end
        else if (line_take)
        begin
            line_valid_reg <= 1'b0;
        end
    end

    // record payload
    always_ff @(posedge clk)
    begin
        if (accept && item.line_end)
        begin
            line_mag_reg  <= line_mag_next;
            line_info_reg <= line_info_next;
        end
    end

    assign line_valid = line_valid_reg;
    assign line_mag   = line_mag_reg;
    assign line_info  = line_info_reg;

endmodule

/* rtl/gawp_scale.sv */
// One axis scaling lane: magnitude times reciprocal unit, then shift, sign
// and saturation to signed Q16.16. Depends on gawp_pkg.
module gawp_scale
    import gawp_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
    input  logic                    clk,
    input  logic                    mul_en,
    input  logic                    sat_en,
    input  logic [31:0]             inverse_unit,
    input  logic [VALUE_BITS-1:0]   mag,
    input  logic                    neg,
    output logic signed [31:0]      pos
);

    localparam int PW = VALUE_BITS + 32;

    logic [PW-1:0]      prod_reg,  prod_next;
    logic               neg_reg;
    logic signed [31:0] pos_reg,   pos_next;
    logic [PW-9:0]      shifted;
    logic               ovf;

    // product stage
    assign prod_next = PW'(mag) * PW'(inverse_unit);

    always_ff @(posedge clk)
    begin
        if (mul_en)
        begin
            prod_reg <= prod_next;
            neg_reg  <= neg;
        end
    end

    // drop the eight extra fraction bits, then sign and saturate
    assign shifted = prod_reg[PW-1:8];
    assign ovf     = |shifted[PW-9:31];

    always_comb
    begin
        if (neg_reg)
        begin
            pos_next = ovf ? 32'sh8000_0000 : -$signed({1'b0, shifted[30:0]});
        end
        else
        begin
            pos_next = ovf ? 32'sh7FFF_FFFF : $signed({1'b0, shifted[30:0]});
        end
    end

    always_ff @(posedge clk)
    begin
        if (sat_en)
        begin
            pos_reg <= pos_next;
        end
    end

    assign pos = pos_reg;

endmodule

/* rtl/gawp_checker.sv */
// Port level checker for gcode_axis_word_parser, with its bind statement.
// Depends on gawp_pkg.
module gawp_checker
    import gawp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    input  logic    item_stall,
    input  item_t   item,
    input  logic    result_valid,
    input  logic    result_stall,
    input  result_t result
);

    logic [2:0] pending_reg;
    logic       line_in;
    logic       res_out;

    assign line_in = item_valid && !item_stall && item.line_end;
    assign res_out = result_valid && !result_stall;

    // lines accepted and not yet delivered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 3'd0;
        end
        else
        begin
            pending_reg <= pending_reg + 3'(line_in) - 3'(res_out);
        end
    end

    // a stalled result beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("stalled result beat changed");

    // never a result without a line behind it, never more in flight than stages
    assert property (@(posedge clk) disable iff (!rst_n)
        (!result_valid || pending_reg != 3'd0) && pending_reg <= 3'd3)
        else $error("result count out of step with lines");

    // with nothing in flight the character side is never held
    assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg == 3'd0 |-> !item_stall)
        else $error("stall with an empty pipeline");

    // a line that is not G code carries zero coordinates
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.move_kind == MOVE_NOT_G |->
            result.x_pos == 0 && result.y_pos == 0 && result.z_pos == 0)
        else $error("coordinates on a non G-code line");

endmodule

bind gcode_axis_word_parser gawp_checker u_gawp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);

/* rtl/gcode_axis_word_parser.sv */
// Top level of the G-code axis word parser: parser, three scaling lanes and
// the result pipeline control. Depends on gawp_pkg, gawp_parse, gawp_scale.

// Takes one character per clock unless stalled, and gives one result beat for
// every line: the line passes from the line record register through the
// per-axis multiply register to the output register. The character side
// stalls only when the line record, product and output stages all hold
// undelivered lines and the result side stalls. Write inverse_unit only while
// no line is in flight.
module gcode_axis_word_parser
    import gawp_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    input  item_t       item,
    output logic        result_valid,
    input  logic        result_stall,
    output result_t     result,
    input  logic        unit_we,
    input  logic [31:0] unit_data
);

    logic [31:0]                     inv_unit_reg;
    logic                            line_valid;
    logic [AXES-1:0][VALUE_BITS-1:0] line_mag;
    line_info_t                      line_info;

    logic       mul_valid_reg;
    logic       out_valid_reg;
    move_kind_t mul_kind_reg;
    move_kind_t out_kind_reg;
    logic       out_en;
    logic       mul_en;

    logic signed [31:0] pos [AXES];

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_unit_reg <= INV_UNIT_RESET;
        end
        else if (unit_we)
        begin
            inv_unit_reg <= unit_data;
        end
    end

    // stage enables: a stage moves when empty or when the next one moves
    assign out_en = !out_valid_reg || !result_stall;
    assign mul_en = !mul_valid_reg || out_en;

    gawp_parse #(
        .VALUE_BITS (VALUE_BITS)
    ) u_parse (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .item_stall (item_stall),
        .line_take  (mul_en),
        .line_valid (line_valid),
        .line_mag   (line_mag),
        .line_info  (line_info)
    );

    // one scaling lane per axis
    for (genvar a = 0; a < AXES; a++)
    begin : g_lane
        gawp_scale #(
            .VALUE_BITS (VALUE_BITS)
        ) u_scale (
            .clk          (clk),
            .mul_en       (mul_en),
            .sat_en       (out_en),
            .inverse_unit (inv_unit_reg),
            .mag          (line_mag[a]),
            .neg          (line_info.neg[a]),
            .pos          (pos[a])
        );
    end

    // valid flags of the product and output stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (mul_en)
            begin
                mul_valid_reg <= line_valid;
            end
            if (out_en)
            begin
                out_valid_reg <= mul_valid_reg;
            end
        end
    end

    // move kind travels alongside the lanes
    always_ff @(posedge clk)
    begin
        if (mul_en)
        begin
            mul_kind_reg <= line_info.kind;
        end
        if (out_en)
        begin
            out_kind_reg <= mul_kind_reg;
        end
    end

    assign result_valid     = out_valid_reg;
    assign result.x_pos     = pos[0];
    assign result.y_pos     = pos[1];
    assign result.z_pos     = pos[2];
    assign result.move_kind = out_kind_reg;

endmodule
